// ===== hw/rtl/dual_range_accel_select_defines.svh =====
// Assertion helpers used by the checker.
`ifndef DUAL_RANGE_ACCEL_SELECT_DEFINES_SVH
`define DUAL_RANGE_ACCEL_SELECT_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define DRAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define DRAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset too.
`define DRAS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dras_pkg.sv =====
package dras_pkg;

    localparam int unsigned AXES       = 3;
    localparam int unsigned RAW_W      = 16;
    localparam int unsigned SCALE_W    = 24;
    localparam int unsigned Q_W        = 32;
    localparam int unsigned CLIP_W     = 16;
    localparam int unsigned RET_W      = 31;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 3 * AXES * RAW_W;
    localparam int unsigned OUT_DATA_W = 2 * AXES * Q_W;
    localparam int unsigned OUT_USER_W = 2;
    localparam int unsigned USER_HIGH_G_USED = 0;
    localparam int unsigned USER_LOW_CLIP    = 1;

    localparam logic [SCALE_W-1:0] LOW_G_SCALE_RST      = 24'd80289;
    localparam logic [SCALE_W-1:0] HIGH_G_SCALE_RST     = 24'd321160;
    localparam logic [SCALE_W-1:0] GYRO_SCALE_RST       = 24'd20497;
    localparam logic [CLIP_W-1:0]  CLIP_THRESHOLD_RST   = 16'd32000;
    localparam logic [RET_W-1:0]   RETURN_THRESHOLD_RST = 31'd8354952;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOW_G_SCALE      = 3'd0,
        REG_HIGH_G_SCALE     = 3'd1,
        REG_GYRO_SCALE       = 3'd2,
        REG_BIAS_X           = 3'd3,
        REG_BIAS_Y           = 3'd4,
        REG_BIAS_Z           = 3'd5,
        REG_CLIP_THRESHOLD   = 3'd6,
        REG_RETURN_THRESHOLD = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [AXES-1:0][RAW_W-1:0] rate;
        logic [AXES-1:0][RAW_W-1:0] high;
        logic [AXES-1:0][RAW_W-1:0] low;
    } raw_t;

    typedef struct packed {
        logic [SCALE_W-1:0] low_g_scale;
        logic [SCALE_W-1:0] high_g_scale;
        logic [SCALE_W-1:0] gyro_scale;
        logic [CLIP_W-1:0]  clip_threshold;
    } scale_cfg_t;

    typedef struct packed {
        logic [AXES-1:0][Q_W-1:0] low_g;
        logic [AXES-1:0][Q_W-1:0] high_g;
        logic [AXES-1:0][Q_W-1:0] gyro;
        logic                     clipped;
    } scaled_t;

endpackage

// ===== hw/rtl/dras_scale.sv =====
module dras_scale (
    input  dras_pkg::raw_t       raw,
    input  dras_pkg::scale_cfg_t cfg,
    output dras_pkg::scaled_t    scaled
);

    localparam int unsigned PROD_W = dras_pkg::RAW_W + dras_pkg::SCALE_W + 1;

    function automatic logic [dras_pkg::Q_W-1:0] scale_q(
        input logic [dras_pkg::RAW_W-1:0]   count,
        input logic [dras_pkg::SCALE_W-1:0] scale
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] rnd;
        prod = PROD_W'($signed(count)) * $signed({1'b0, scale});
        rnd  = (prod + PROD_W'(128)) >>> 8;
        // |count * scale| < 2^39, so the rounded value always fits 32 bits
        return rnd[dras_pkg::Q_W-1:0];
    endfunction

    logic [dras_pkg::AXES-1:0] clip_hit;

    always_comb begin
        for (int i = 0; i < dras_pkg::AXES; i++) begin
            logic [dras_pkg::RAW_W:0] mag;
            mag = raw.low[i][dras_pkg::RAW_W-1]
                ? (dras_pkg::RAW_W+1)'(~{1'b1, raw.low[i]} + 1'b1)
                : {1'b0, raw.low[i]};
            clip_hit[i]        = mag >= {1'b0, cfg.clip_threshold};
            scaled.low_g[i]    = scale_q(raw.low[i], cfg.low_g_scale);
            scaled.high_g[i]   = scale_q(raw.high[i], cfg.high_g_scale);
            scaled.gyro[i]     = scale_q(raw.rate[i], cfg.gyro_scale);
        end
        scaled.clipped = |clip_hit;
    end

endmodule

// ===== hw/rtl/dual_range_accel_select.sv =====
// Channel | Dir | Payload (low bit first)                            | Beat taken when
// s_      | in  | tdata: low_x..z, high_x..z, rate_x..z (16b each)   | s_tvalid & s_tready
// m_      | out | tdata: accel_x..z, gyro_x..z (32b); tuser: used,clip | m_tvalid & m_tready
// cfg_    | in  | cfg_addr register index, cfg_data value             | cfg_valid & cfg_ready
//
// Three-stage pipeline: input register, scaled register, result register.
// One beat per cycle sustained while m_tready is high.
// The 16x24 scaling multipliers set the stage between input and scaled register.
// aresetn is synchronous: clears valids and the high-g selection, reloads config defaults.
// A stall on m_tready backs up stage by stage; bubbles are filled while stalled.
module dual_range_accel_select (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // low_x, low_y, low_z, high_x, high_y, high_z, rate_x, rate_y, rate_z
    input  logic [dras_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    output logic [dras_pkg::OUT_DATA_W-1:0]     m_tdata,
    // high_g_used, low_clip
    output logic [dras_pkg::OUT_USER_W-1:0]     m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dras_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dras_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned AXES = dras_pkg::AXES;
    localparam int unsigned Q_W  = dras_pkg::Q_W;

    dras_pkg::scale_cfg_t                     scale_cfg_reg;
    logic [AXES-1:0][Q_W-1:0]                 bias_reg;
    logic [dras_pkg::RET_W-1:0]               return_threshold_reg;

    logic                                     in_valid_reg;
    dras_pkg::raw_t                           in_data_reg;
    logic                                     sc_valid_reg;
    dras_pkg::scaled_t                        sc_data_reg;
    dras_pkg::scaled_t                        sc_data_next;
    logic                                     out_valid_reg;
    logic [2*AXES-1:0][Q_W-1:0]               out_data_reg;
    logic [2*AXES-1:0][Q_W-1:0]               out_data_next;
    logic [dras_pkg::OUT_USER_W-1:0]          out_user_reg;
    logic [dras_pkg::OUT_USER_W-1:0]          out_user_next;
    logic                                     using_high_g_reg;
    logic                                     using_high_g_next;

    logic out_ready;
    logic sc_ready;
    logic in_ready;
    logic sc_move;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_cfg_reg.low_g_scale    <= dras_pkg::LOW_G_SCALE_RST;
            scale_cfg_reg.high_g_scale   <= dras_pkg::HIGH_G_SCALE_RST;
            scale_cfg_reg.gyro_scale     <= dras_pkg::GYRO_SCALE_RST;
            scale_cfg_reg.clip_threshold <= dras_pkg::CLIP_THRESHOLD_RST;
            bias_reg                     <= '0;
            return_threshold_reg         <= dras_pkg::RETURN_THRESHOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (dras_pkg::cfg_index_t'(cfg_addr))
                dras_pkg::REG_LOW_G_SCALE: begin
                    scale_cfg_reg.low_g_scale <= cfg_data[dras_pkg::SCALE_W-1:0];
                end
                dras_pkg::REG_HIGH_G_SCALE: begin
                    scale_cfg_reg.high_g_scale <= cfg_data[dras_pkg::SCALE_W-1:0];
                end
                dras_pkg::REG_GYRO_SCALE: begin
                    scale_cfg_reg.gyro_scale <= cfg_data[dras_pkg::SCALE_W-1:0];
                end
                dras_pkg::REG_BIAS_X:         bias_reg[0] <= cfg_data;
                dras_pkg::REG_BIAS_Y:         bias_reg[1] <= cfg_data;
                dras_pkg::REG_BIAS_Z:         bias_reg[2] <= cfg_data;
                dras_pkg::REG_CLIP_THRESHOLD: begin
                    scale_cfg_reg.clip_threshold <= cfg_data[dras_pkg::CLIP_W-1:0];
                end
                dras_pkg::REG_RETURN_THRESHOLD: begin
                    return_threshold_reg <= cfg_data[dras_pkg::RET_W-1:0];
                end
            endcase
        end
    end

    assign out_ready = !out_valid_reg || m_tready;
    assign sc_ready  = !sc_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || sc_ready;
    assign sc_move   = sc_valid_reg && out_ready;
    assign s_tready  = in_ready;

    dras_scale u_scale (
        .raw    (in_data_reg),
        .cfg    (scale_cfg_reg),
        .scaled (sc_data_next)
    );

    // hysteresis select and gyro bias removal
    always_comb begin
        logic [Q_W-1:0] peak;
        logic [Q_W-1:0] mag;
        logic [Q_W:0]   diff;
        logic           keep_high;
        peak = '0;
        for (int i = 0; i < AXES; i++) begin
            mag = sc_data_reg.high_g[i][Q_W-1] ? (~sc_data_reg.high_g[i] + 1'b1)
                                               : sc_data_reg.high_g[i];
            if (mag > peak) begin
                peak = mag;
            end
        end
        keep_high = using_high_g_reg && (peak >= {1'b0, return_threshold_reg});
        using_high_g_next = sc_data_reg.clipped || keep_high;
        for (int i = 0; i < AXES; i++) begin
            out_data_next[i] = using_high_g_next ? sc_data_reg.high_g[i]
                                                 : sc_data_reg.low_g[i];
            diff = $signed({sc_data_reg.gyro[i][Q_W-1], sc_data_reg.gyro[i]})
                 - $signed({bias_reg[i][Q_W-1], bias_reg[i]});
            if (diff[Q_W] != diff[Q_W-1]) begin
                out_data_next[AXES+i] = diff[Q_W] ? {1'b1, {(Q_W-1){1'b0}}}
                                                  : {1'b0, {(Q_W-1){1'b1}}};
            end else begin
                out_data_next[AXES+i] = diff[Q_W-1:0];
            end
        end
        out_user_next = '0;
        out_user_next[dras_pkg::USER_HIGH_G_USED] = using_high_g_next;
        out_user_next[dras_pkg::USER_LOW_CLIP]    = sc_data_reg.clipped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            sc_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            using_high_g_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_tvalid;
            end
            if (sc_ready) begin
                sc_valid_reg <= in_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= sc_valid_reg;
            end
            if (sc_move) begin
                using_high_g_reg <= using_high_g_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            in_data_reg <= dras_pkg::raw_t'(s_tdata);
        end
        if (sc_ready && in_valid_reg) begin
            sc_data_reg <= sc_data_next;
        end
        if (sc_move) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== hw/rtl/dras_check.sv =====
`include "dual_range_accel_select_defines.svh"

module dras_check (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dras_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [dras_pkg::OUT_USER_W-1:0] m_tuser
);

    `DRAS_ASSERT_NOW(a_clip_forces_high, aclk, aresetn,
        m_tvalid && m_tuser[dras_pkg::USER_LOW_CLIP],
        m_tuser[dras_pkg::USER_HIGH_G_USED], "clipped beat not taken from high-g")

    `DRAS_ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid,
        "result valid right after reset")

    `DRAS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid,
        "result beat dropped while stalled")

    `DRAS_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

endmodule

bind dual_range_accel_select dras_check u_dras_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
